[rtl/dcsr_pkg.sv]
// shared types, codes and constants of the depth-cued slice renderer
`default_nettype none

package dcsr_pkg;

  localparam int SIDE_DEFAULT   = 128;
  localparam int PHASES_DEFAULT = 64;
  localparam int MAX_SCALE      = 8;
  localparam int DEPTH_LIMIT    = 10;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 8;

  // input item commands
  localparam logic [1:0] CMD_VOXEL   = 2'd0;
  localparam logic [1:0] CMD_PALETTE = 2'd1;
  localparam logic [1:0] CMD_RENDER  = 2'd2;

  // view plane codes
  localparam logic [1:0] PLANE_XY = 2'd0;
  localparam logic [1:0] PLANE_XZ = 2'd1;
  localparam logic [1:0] PLANE_YZ = 2'd2;

  // configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_VIEW_PLANE = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_MAGNIFY    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_PORE_PHASE = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_EXTENT_X   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_EXTENT_Y   = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_EXTENT_Z   = 3'd5;

  typedef struct packed {
    logic [1:0] command;
    logic [6:0] vox_x;
    logic [6:0] vox_y;
    logic [6:0] vox_z;
    logic [5:0] phase;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [6:0] slice;
    logic [9:0] out_col;
    logic [9:0] out_row;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [3:0] depth_steps;
    logic [5:0] phase_found;
    logic       range_error;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_RANGE,
    ST_WALK,
    ST_PAL,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic accept;
    logic load_req;
    logic div_step;
    logic check;
    logic walk_init;
    logic walk_advance;
    logic vol_read;
    logic pal_read;
    logic shade_load;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_last;
    logic range_err;
    logic stop;
    logic out_free;
  } ctrl_status_t;

endpackage

`default_nettype wire

[rtl/depth_cued_slice_renderer.sv]
// top level of the depth-cued slice renderer
//
// channel  dir  signals                               item taken when
// req      in   req_valid, req_ready, req             req_valid && req_ready
// rsp      out  rsp_valid, rsp_ready, rsp             rsp_valid && rsp_ready
// cfg      in   cfg_valid, cfg_ready, cfg_index/data  cfg_valid && cfg_ready (ready always high)
//
// voxel and palette writes give no result.
// a render runs the bit-serial column/row divider, one range check, then n = 1..11 volume
// reads, one per walk step, then palette read and shading; a range error skips the walk
// and the shading.
// reset clears the configuration registers and control state; the memories are not cleared.
// a result held in rsp stalls the next render in its finish state; no item is accepted while it waits.
`default_nettype none

module depth_cued_slice_renderer #(
  parameter int SIDE   = dcsr_pkg::SIDE_DEFAULT,
  parameter int PHASES = dcsr_pkg::PHASES_DEFAULT
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             req_valid,
  output logic                                  req_ready,
  input  wire dcsr_pkg::in_item_t               req,
  output logic                                  rsp_valid,
  input  wire logic                             rsp_ready,
  output dcsr_pkg::out_item_t                   rsp,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [dcsr_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [dcsr_pkg::CFG_DATA_W-1:0]  cfg_data
);

  import dcsr_pkg::*;

  ctrl_cmd_t    cmd;
  ctrl_status_t st;

  assign cfg_ready = 1'b1;

  dcsr_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_command(req.command),
    .req_ready  (req_ready),
    .cmd        (cmd),
    .st         (st)
  );

  dcsr_datapath #(
    .SIDE  (SIDE),
    .PHASES(PHASES)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cfg_valid(cfg_valid),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .req      (req),
    .cmd      (cmd),
    .st       (st),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

endmodule

`default_nettype wire

[rtl/dcsr_ram.sv]
// generic single write port, single read port ram with registered read
`default_nettype none

module dcsr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[rtl/dcsr_ctrl.sv]
// controller state machine of the slice renderer
`default_nettype none

module dcsr_ctrl (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    req_valid,
  input  wire logic [1:0]              req_command,
  output logic                         req_ready,
  output dcsr_pkg::ctrl_cmd_t          cmd,
  input  wire dcsr_pkg::ctrl_status_t  st
);

  import dcsr_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.accept = 1'b1;
          if (req_command == CMD_RENDER) begin
            cmd.load_req = 1'b1;
            state_next   = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (st.div_last) begin
          state_next = ST_RANGE;
        end
      end
      ST_RANGE: begin
        cmd.check = 1'b1;
        if (st.range_err) begin
          state_next = ST_FINISH;
        end else begin
          cmd.walk_init = 1'b1;
          cmd.vol_read  = 1'b1;
          state_next    = ST_WALK;
        end
      end
      ST_WALK: begin
        if (st.stop) begin
          cmd.pal_read = 1'b1;
          state_next   = ST_PAL;
        end else begin
          cmd.walk_advance = 1'b1;
          cmd.vol_read     = 1'b1;
        end
      end
      ST_PAL: begin
        cmd.shade_load = 1'b1;
        state_next     = ST_FINISH;
      end
      ST_FINISH: begin
        // hold until the output register can take the item
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/dcsr_datapath.sv]
// datapath of the slice renderer: config, divider, walk, memories, shading, output register
`default_nettype none

module dcsr_datapath #(
  parameter int SIDE   = dcsr_pkg::SIDE_DEFAULT,
  parameter int PHASES = dcsr_pkg::PHASES_DEFAULT
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_valid,
  input  wire logic [dcsr_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  wire logic [dcsr_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire dcsr_pkg::in_item_t                 req,
  input  wire dcsr_pkg::ctrl_cmd_t                cmd,
  output dcsr_pkg::ctrl_status_t                  st,
  output logic                                    rsp_valid,
  input  wire logic                               rsp_ready,
  output dcsr_pkg::out_item_t                     rsp
);

  import dcsr_pkg::*;

  localparam int CW    = $clog2(SIDE);
  localparam int EW    = (CW + 1 > 8) ? CW + 1 : 8;
  localparam int VAW   = 3 * CW;
  localparam int PW    = $clog2(PHASES);
  localparam int QW    = 10;
  localparam int CMPW  = (EW > QW) ? EW : QW;
  localparam int MW    = 5;
  localparam int NUMW  = 14;
  localparam int DIVISOR = 2 * DEPTH_LIMIT;
  localparam int SHIFT = NUMW + $clog2(DIVISOR);
  localparam int RECIP = (2 ** SHIFT + DIVISOR - 1) / DIVISOR;
  localparam int RW    = NUMW + 2;
  localparam int PRW   = NUMW + RW;

  localparam logic [3:0]    LIMIT4 = 4'(DEPTH_LIMIT);
  localparam logic [MW-1:0] MAXS   = MW'(MAX_SCALE);
  localparam logic [EW-1:0] SIDE_E = EW'(SIDE);

  // configuration registers
  logic [1:0] view_plane;
  logic [3:0] magnify;
  logic [5:0] pore_phase;
  logic [7:0] extent_x;
  logic [7:0] extent_y;
  logic [7:0] extent_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      view_plane <= PLANE_XY;
      magnify    <= 4'd1;
      pore_phase <= 6'd0;
      extent_x   <= 8'd128;
      extent_y   <= 8'd128;
      extent_z   <= 8'd128;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_VIEW_PLANE: view_plane <= cfg_data[1:0];
        CFG_MAGNIFY:    magnify    <= cfg_data[3:0];
        CFG_PORE_PHASE: pore_phase <= cfg_data[5:0];
        CFG_EXTENT_X:   extent_x   <= cfg_data;
        CFG_EXTENT_Y:   extent_y   <= cfg_data;
        CFG_EXTENT_Z:   extent_z   <= cfg_data;
        default: ;
      endcase
    end
  end

  function automatic logic [EW-1:0] clamp_extent(input logic [7:0] e);
    logic [EW-1:0] ee;
    ee = EW'(e);
    return (ee > SIDE_E) ? SIDE_E : ee;
  endfunction

  logic [MW-1:0] mag;
  logic [MW-1:0] mag_raw;
  assign mag_raw = MW'(magnify);
  assign mag = (magnify == 4'd0) ? MW'(1) : ((mag_raw > MAXS) ? MAXS : mag_raw);

  logic [EW-1:0] ex;
  logic [EW-1:0] ey;
  logic [EW-1:0] ez;
  assign ex = clamp_extent(extent_x);
  assign ey = clamp_extent(extent_y);
  assign ez = clamp_extent(extent_z);

  logic [EW-1:0] nsl;
  logic [EW-1:0] dxe;
  logic [EW-1:0] dye;
  logic          plane_bad;

  always_comb begin
    plane_bad = 1'b0;
    unique case (view_plane)
      PLANE_XY: begin nsl = ez; dxe = ex; dye = ey; end
      PLANE_XZ: begin nsl = ey; dxe = ex; dye = ez; end
      PLANE_YZ: begin nsl = ex; dxe = ey; dye = ez; end
      default: begin
        nsl = '0; dxe = '0; dye = '0;
        plane_bad = 1'b1;
      end
    endcase
  end

  // request capture and bit-serial divider for column and row
  logic [6:0]    slice_r;
  logic [QW-1:0] qc;
  logic [QW-1:0] qr;
  logic [MW-1:0] rc;
  logic [MW-1:0] rr;
  logic [3:0]    div_cnt;

  logic [MW:0]   tc;
  logic [MW:0]   tr;
  logic [MW:0]   dc;
  logic [MW:0]   dr;
  logic          gec;
  logic          ger;

  assign tc  = {rc, qc[QW-1]};
  assign tr  = {rr, qr[QW-1]};
  assign gec = tc >= {1'b0, mag};
  assign ger = tr >= {1'b0, mag};
  assign dc  = gec ? tc - {1'b0, mag} : tc;
  assign dr  = ger ? tr - {1'b0, mag} : tr;

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (cmd.load_req) begin
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      div_cnt <= div_cnt + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      slice_r <= req.slice;
      qc      <= req.out_col;
      qr      <= req.out_row;
      rc      <= '0;
      rr      <= '0;
    end else if (cmd.div_step) begin
      // dividend bits shift out the top, quotient bits shift in below
      qc <= {qc[QW-2:0], gec};
      qr <= {qr[QW-2:0], ger};
      rc <= dc[MW-1:0];
      rr <= dr[MW-1:0];
    end
  end

  assign st.div_last = div_cnt == 4'(QW - 1);

  // range check
  logic range_err;
  logic err_r;
  assign range_err = plane_bad || (CMPW'(slice_r) >= CMPW'(nsl)) ||
                     (CMPW'(qc) >= CMPW'(dxe)) || (CMPW'(qr) >= CMPW'(dye));
  assign st.range_err = range_err;

  always_ff @(posedge clk) begin
    if (cmd.check) begin
      err_r <= range_err;
    end
  end

  // walk along the viewing axis
  logic [CW-1:0] d_r;
  logic [3:0]    steps_r;
  logic [5:0]    found_r;
  logic [EW-1:0] d_inc;
  logic [CW-1:0] d_next;
  logic [CW-1:0] d_rd;
  logic [9:0]    slice_w;
  logic [CW-1:0] slice_cw;
  logic [CW-1:0] ic;
  logic [CW-1:0] jc;
  logic [VAW-1:0] vol_raddr;
  logic [5:0]    vol_rdata;

  assign slice_w  = 10'(slice_r);
  assign slice_cw = slice_w[CW-1:0];
  assign ic       = qc[CW-1:0];
  assign jc       = qr[CW-1:0];
  assign d_inc    = EW'(d_r) + EW'(1);
  assign d_next   = (d_inc >= nsl) ? '0 : d_inc[CW-1:0];
  assign d_rd     = cmd.walk_init ? slice_cw : d_next;

  always_comb begin
    unique case (view_plane)
      PLANE_XY: vol_raddr = {ic, jc, d_rd};
      PLANE_XZ: vol_raddr = {ic, d_rd, jc};
      default:  vol_raddr = {d_rd, ic, jc};
    endcase
  end

  assign st.stop = (steps_r >= LIMIT4) || (vol_rdata != pore_phase);

  always_ff @(posedge clk) begin
    if (cmd.walk_init) begin
      d_r     <= slice_cw;
      steps_r <= '0;
    end else if (cmd.walk_advance) begin
      d_r     <= d_next;
      steps_r <= steps_r + 4'd1;
    end
    if (cmd.pal_read) begin
      found_r <= vol_rdata;
    end
  end

  // volume memory
  logic [9:0]     vx_w;
  logic [9:0]     vy_w;
  logic [9:0]     vz_w;
  logic           vol_we;
  logic [VAW-1:0] vol_waddr;

  assign vx_w = 10'(req.vox_x);
  assign vy_w = 10'(req.vox_y);
  assign vz_w = 10'(req.vox_z);
  assign vol_we = cmd.accept && (req.command == CMD_VOXEL) &&
                  (vx_w < 10'(SIDE)) && (vy_w < 10'(SIDE)) && (vz_w < 10'(SIDE)) &&
                  (9'(req.phase) < 9'(PHASES));
  assign vol_waddr = {vx_w[CW-1:0], vy_w[CW-1:0], vz_w[CW-1:0]};

  dcsr_ram #(
    .WIDTH(6),
    .DEPTH(1 << VAW)
  ) u_volume (
    .clk  (clk),
    .we   (vol_we),
    .waddr(vol_waddr),
    .wdata(req.phase),
    .re   (cmd.vol_read),
    .raddr(vol_raddr),
    .rdata(vol_rdata)
  );

  // palette memory
  logic [7:0]    phase_w;
  logic [7:0]    found_w;
  logic          pal_we;
  logic [23:0]   pal_rdata;

  assign phase_w = 8'(req.phase);
  assign found_w = 8'(vol_rdata);
  assign pal_we  = cmd.accept && (req.command == CMD_PALETTE) &&
                   (9'(req.phase) < 9'(PHASES));

  dcsr_ram #(
    .WIDTH(24),
    .DEPTH(PHASES)
  ) u_palette (
    .clk  (clk),
    .we   (pal_we),
    .waddr(phase_w[PW-1:0]),
    .wdata({req.red, req.green, req.blue}),
    .re   (cmd.pal_read),
    .raddr(found_w[PW-1:0]),
    .rdata(pal_rdata)
  );

  // shading: (2*c*w + limit) / (2*limit), division by reciprocal multiply
  logic [3:0]      weight;
  logic [NUMW-1:0] num_next [3];
  logic [NUMW-1:0] num_r [3];
  logic [PRW-1:0]  prod [3];
  logic [7:0]      shaded [3];
  logic [RW-1:0]   recip;

  assign weight = LIMIT4 - steps_r;
  assign recip  = RW'(RECIP);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      num_next[k] = NUMW'({12'(pal_rdata[8*(2-k) +: 8]) * 12'(weight), 1'b0}) +
                    NUMW'(DEPTH_LIMIT);
      prod[k]     = PRW'(num_r[k]) * PRW'(recip);
      shaded[k]   = prod[k][SHIFT +: 8];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.shade_load) begin
      for (int k = 0; k < 3; k++) begin
        num_r[k] <= num_next[k];
      end
    end
  end

  // output register
  assign st.out_free = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.out_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (err_r) begin
        rsp <= '{red_out: 8'd0, green_out: 8'd0, blue_out: 8'd0,
                 depth_steps: 4'd0, phase_found: 6'd0, range_error: 1'b1};
      end else begin
        rsp <= '{red_out: shaded[0], green_out: shaded[1], blue_out: shaded[2],
                 depth_steps: steps_r, phase_found: found_r, range_error: 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

[bench/tb_top.sv]
// self-checking testbench for the depth-cued slice renderer: loads, renders and settings
module tb_top;
  import dcsr_pkg::*;

  localparam int HALF_PERIOD   = 6;
  localparam int RESET_CYCLES  = 10;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int PHASE_ITEMS   = 150;
  localparam int RANDOM_PHASES = 7;
  localparam int VOL_SIDE      = SIDE_DEFAULT;

  localparam logic [1:0] CMD_NOP    = 2'd3;
  localparam logic [1:0] PLANE_NONE = 2'd3;

  class slice_scoreboard;
    bit [5:0]  voxels[int];
    bit [23:0] palette[PHASES_DEFAULT];
    bit [1:0]  plane;
    bit [3:0]  mag;
    bit [5:0]  pore;
    bit [7:0]  ext_x, ext_y, ext_z;
    int        miss_addr;
    out_item_t pixels_due[$];
    int        fails, renders, range_errs, deep_hits, matched;

    function new();
      plane = PLANE_XY;
      mag   = 4'd1;
      pore  = 6'd0;
      ext_x = 8'd128;
      ext_y = 8'd128;
      ext_z = 8'd128;
      fails = 0;
      renders = 0;
      range_errs = 0;
      deep_hits = 0;
      matched = 0;
    endfunction

    function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_VIEW_PLANE: plane = data[1:0];
        CFG_MAGNIFY:    mag   = data[3:0];
        CFG_PORE_PHASE: pore  = data[5:0];
        CFG_EXTENT_X:   ext_x = data;
        CFG_EXTENT_Y:   ext_y = data;
        CFG_EXTENT_Z:   ext_z = data;
        default: ;
      endcase
    endfunction

    function int side_limited(bit [7:0] e);
      return (e > VOL_SIDE) ? VOL_SIDE : int'(e);
    endfunction

    function int vox_addr(int x, int y, int z);
      return (x * VOL_SIDE + y) * VOL_SIDE + z;
    endfunction

    // slices along depth, plane size in voxels and effective scale; 0 for the unused plane
    function bit plane_dims(output int ns, output int dx, output int dy, output int m);
      int ex, ey, ez;
      ex = side_limited(ext_x);
      ey = side_limited(ext_y);
      ez = side_limited(ext_z);
      m = (mag == 0) ? 1 : (mag > MAX_SCALE) ? MAX_SCALE : int'(mag);
      case (plane)
        PLANE_XY: begin ns = ez; dx = ex; dy = ey; end
        PLANE_XZ: begin ns = ey; dx = ex; dy = ez; end
        PLANE_YZ: begin ns = ex; dx = ey; dy = ez; end
        default: begin
          ns = 0; dx = 0; dy = 0;
          return 1'b0;
        end
      endcase
      return 1'b1;
    endfunction

    function bit [7:0] shade(bit [7:0] c, int steps);
      return 8'((2 * int'(c) * (DEPTH_LIMIT - steps) + DEPTH_LIMIT) / (2 * DEPTH_LIMIT));
    endfunction

    // miss_addr ends up >= 0 when the walk would touch a voxel never loaded
    function out_item_t predict_pixel(in_item_t it);
      out_item_t px;
      int ns, dx, dy, m, i, j, d, steps, addr;
      bit [5:0] found;
      bit [23:0] color;
      px = '0;
      miss_addr = -1;
      if (!plane_dims(ns, dx, dy, m)) begin
        px.range_error = 1'b1;
        return px;
      end
      i = int'(it.out_col) / m;
      j = int'(it.out_row) / m;
      if (int'(it.slice) >= ns || i >= dx || j >= dy) begin
        px.range_error = 1'b1;
        return px;
      end
      d = int'(it.slice);
      steps = 0;
      forever begin
        case (plane)
          PLANE_XY: addr = vox_addr(i, j, d);
          PLANE_XZ: addr = vox_addr(i, d, j);
          default:  addr = vox_addr(d, i, j);
        endcase
        if (!voxels.exists(addr)) begin
          miss_addr = addr;
          return px;
        end
        found = voxels[addr];
        if (steps >= DEPTH_LIMIT || found != pore) break;
        steps++;
        d++;
        if (d >= ns) d -= ns;
      end
      color = palette[found];
      px.red_out     = shade(color[23:16], steps);
      px.green_out   = shade(color[15:8], steps);
      px.blue_out    = shade(color[7:0], steps);
      px.depth_steps = 4'(steps);
      px.phase_found = found;
      return px;
    endfunction

    function void take_item(in_item_t it);
      out_item_t px;
      case (it.command)
        CMD_VOXEL:   voxels[vox_addr(int'(it.vox_x), int'(it.vox_y), int'(it.vox_z))] = it.phase;
        CMD_PALETTE: palette[it.phase] = {it.red, it.green, it.blue};
        CMD_RENDER: begin
          px = predict_pixel(it);
          pixels_due.push_back(px);
          renders++;
          if (px.range_error) range_errs++;
          else if (px.depth_steps == DEPTH_LIMIT) deep_hits++;
        end
        default: ;
      endcase
    endfunction

    function void cmp_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        fails++;
      end
    endfunction

    function void check_pixel(out_item_t got);
      out_item_t want;
      int before_fails;
      if (pixels_due.size() == 0) begin
        $display("%0t: pixel arrived with no render pending, expected none, got %h",
                 $time, got);
        fails++;
        return;
      end
      want = pixels_due.pop_front();
      before_fails = fails;
      cmp_field("red_out", want.red_out, got.red_out);
      cmp_field("green_out", want.green_out, got.green_out);
      cmp_field("blue_out", want.blue_out, got.blue_out);
      cmp_field("depth_steps", 8'(want.depth_steps), 8'(got.depth_steps));
      cmp_field("phase_found", 8'(want.phase_found), 8'(got.phase_found));
      cmp_field("range_error", 8'(want.range_error), 8'(got.range_error));
      if (fails == before_fails) matched++;
    endfunction
  endclass

  logic                   clk;
  logic                   rst;
  logic                   req_valid;
  logic                   req_ready;
  in_item_t               req;
  logic                   rsp_valid;
  logic                   rsp_ready;
  out_item_t              rsp;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  slice_scoreboard sb;
  bit              calm;
  int              items_sent;
  int              settings_used;

  depth_cued_slice_renderer i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #HALF_PERIOD clk = ~clk;
  end

  function automatic in_item_t noise_item(logic [1:0] cmd);
    bit [95:0] r;
    in_item_t it;
    r = {$urandom, $urandom, $urandom};
    it = r[$bits(in_item_t)-1:0];
    it.command = cmd;
    return it;
  endfunction

  function automatic in_item_t voxel_at(int x, int y, int z, int ph);
    in_item_t it;
    it = noise_item(CMD_VOXEL);
    it.vox_x = 7'(x);
    it.vox_y = 7'(y);
    it.vox_z = 7'(z);
    it.phase = 6'(ph);
    return it;
  endfunction

  function automatic in_item_t palette_at(int idx, logic [23:0] rgb);
    in_item_t it;
    it = noise_item(CMD_PALETTE);
    it.phase = 6'(idx);
    {it.red, it.green, it.blue} = rgb;
    return it;
  endfunction

  function automatic in_item_t pixel_at(int sl, int col, int row);
    in_item_t it;
    it = noise_item(CMD_RENDER);
    it.slice   = 7'(sl);
    it.out_col = 10'(col);
    it.out_row = 10'(row);
    return it;
  endfunction

  // pore-heavy so walks get long
  function automatic logic [5:0] pick_phase();
    case ($urandom_range(0, 3))
      0, 1:    return sb.pore;
      2:       return 6'($urandom_range(0, 3));
      default: return 6'($urandom_range(0, 63));
    endcase
  endfunction

  function automatic logic [7:0] pick_extent();
    int dice;
    dice = $urandom_range(0, 19);
    if (dice == 0) return 8'd0;
    if (dice < 4) return 8'd128;
    if (dice < 6) return 8'($urandom_range(129, 255));
    return 8'($urandom_range(1, 8));
  endfunction

  // sometimes set the register bits above the field
  function automatic logic [7:0] junk_above(logic [7:0] v, int w);
    logic [7:0] mask;
    logic [7:0] r;
    mask = 8'hff << w;
    r = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 3) == 0) return (v & ~mask) | (r & mask);
    return v;
  endfunction

  task automatic send_item(in_item_t it);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req       <= it;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
    sb.take_item(it);
    if (it.command != CMD_NOP) items_sent++;
  endtask

  // load any voxel the walk would read before it was ever written, then render
  task automatic render_pixel(in_item_t it);
    int a;
    forever begin
      void'(sb.predict_pixel(it));
      if (sb.miss_addr < 0) break;
      a = sb.miss_addr;
      send_item(voxel_at(a / (VOL_SIDE * VOL_SIDE), (a / VOL_SIDE) % VOL_SIDE,
                         a % VOL_SIDE, pick_phase()));
    end
    send_item(it);
  endtask

  task automatic settle();
    req_valid <= 1'b0;
    @(posedge clk);
    while (sb.pixels_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_settings(logic [1:0] plane, logic [3:0] mag, logic [5:0] pore,
                               logic [7:0] ex, logic [7:0] ey, logic [7:0] ez);
    logic [CFG_INDEX_W-1:0] idx[6];
    logic [CFG_DATA_W-1:0]  val[6];
    settle();
    idx = '{CFG_VIEW_PLANE, CFG_MAGNIFY, CFG_PORE_PHASE,
            CFG_EXTENT_X, CFG_EXTENT_Y, CFG_EXTENT_Z};
    val = '{junk_above(8'(plane), 2), junk_above(8'(mag), 4), junk_above(8'(pore), 6),
            ex, ey, ez};
    for (int n = 0; n < 6; n++) begin
      cfg_index <= idx[n];
      cfg_data  <= val[n];
      cfg_valid <= 1'b1;
      do @(posedge clk); while (!cfg_ready);
      sb.set_reg(idx[n], val[n]);
    end
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic run_random(int count);
    in_item_t it;
    int ns, dx, dy, m, goal, dice;
    int bx, by, bz;
    goal = items_sent + count;
    void'(sb.plane_dims(ns, dx, dy, m));
    bx = sb.side_limited(sb.ext_x);
    by = sb.side_limited(sb.ext_y);
    bz = sb.side_limited(sb.ext_z);
    if (bx == 0) bx = VOL_SIDE;
    if (by == 0) by = VOL_SIDE;
    if (bz == 0) bz = VOL_SIDE;
    calm = ($urandom_range(0, 3) == 0);
    while (items_sent < goal) begin
      if ($urandom_range(0, 47) == 0) calm = !calm;
      // hold off until every pixel is back
      if ($urandom_range(0, 149) == 0) settle();
      dice = $urandom_range(0, 19);
      if (dice < 7) begin
        it = noise_item(CMD_VOXEL);
        if ($urandom_range(0, 3) != 0) begin
          it.vox_x = 7'($urandom_range(0, bx - 1));
          it.vox_y = 7'($urandom_range(0, by - 1));
          it.vox_z = 7'($urandom_range(0, bz - 1));
        end
        it.phase = pick_phase();
        send_item(it);
      end else if (dice < 9) begin
        it = noise_item(CMD_PALETTE);
        if ($urandom_range(0, 3) == 0)
          {it.red, it.green, it.blue} = $urandom_range(0, 1) ? 24'hffffff : 24'h000000;
        send_item(it);
      end else if (dice == 9) begin
        send_item(noise_item(CMD_NOP));
      end else begin
        it = noise_item(CMD_RENDER);
        if ($urandom_range(0, 4) != 0 && ns > 0 && dx > 0 && dy > 0) begin
          it.slice   = 7'($urandom_range(0, ns - 1));
          it.out_col = 10'($urandom_range(0, dx * m - 1));
          it.out_row = 10'($urandom_range(0, dy * m - 1));
        end
        render_pixel(it);
      end
    end
  endtask

  // result side
  initial begin
    int stall;
    rsp_ready <= 1'b0;
    @(negedge rst);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        rsp_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp_ready <= 1'b1;
      do @(posedge clk); while (!rsp_valid);
      sb.check_pixel(rsp);
    end
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    sb = new();
    calm = 1'b0;
    items_sent = 0;
    settings_used = 0;
    rst       <= 1'b1;
    req_valid <= 1'b0;
    req       <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // whole palette first so no render ever reads an empty entry
    for (int k = 0; k < PHASES_DEFAULT; k++) begin
      if (k == PHASES_DEFAULT - 1) send_item(palette_at(k, 24'hffffff));
      else send_item(palette_at(k, 24'($urandom_range(0, 24'hffffff))));
    end

    // reset settings: xy plane, scale 1, pore 0, full extents
    send_item(voxel_at(127, 127, 127, 63));
    render_pixel(pixel_at(127, 127, 127));
    // walk through two pore voxels and wrap past the last slice
    send_item(voxel_at(1, 0, 126, 0));
    send_item(voxel_at(1, 0, 127, 0));
    send_item(voxel_at(1, 0, 0, 5));
    render_pixel(pixel_at(126, 1, 0));
    send_item(palette_at(5, 24'h000000));
    render_pixel(pixel_at(126, 1, 0));
    send_item(voxel_at(0, 0, 0, 7));
    render_pixel(pixel_at(0, 0, 0));
    render_pixel(pixel_at(0, 1023, 0));
    render_pixel(pixel_at(0, 0, 1023));
    render_pixel(pixel_at(3, 128, 5));
    send_item('1);

    // single voxel volume: a pore voxel is seen again on every step
    load_settings(PLANE_XY, 4'd8, 6'd0, 8'd1, 8'd1, 8'd1);
    send_item(voxel_at(0, 0, 0, 0));
    render_pixel(pixel_at(0, 7, 7));
    render_pixel(pixel_at(0, 8, 0));
    run_random(PHASE_ITEMS);

    load_settings(PLANE_XZ, 4'd0, 6'd63, 8'd128, 8'd128, 8'd128);
    run_random(PHASE_ITEMS);
    load_settings(PLANE_YZ, 4'd15, 6'd3, 8'd255, 8'd6, 8'd5);
    run_random(PHASE_ITEMS);
    load_settings(PLANE_NONE, 4'd2, 6'd1, 8'd4, 8'd4, 8'd4);
    run_random(PHASE_ITEMS);
    load_settings(PLANE_XY, 4'd3, 6'd2, 8'd0, 8'd5, 8'd5);
    run_random(PHASE_ITEMS);

    for (int k = 0; k < RANDOM_PHASES; k++) begin
      load_settings(($urandom_range(0, 9) == 0) ? PLANE_NONE : 2'($urandom_range(0, 2)),
                    ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
                                                : 4'($urandom_range(1, 8)),
                    ($urandom_range(0, 1) == 1) ? 6'($urandom_range(0, 3))
                                                : 6'($urandom_range(0, 63)),
                    pick_extent(), pick_extent(), pick_extent());
      run_random(PHASE_ITEMS);
    end

    settle();
    $display("%0d items under %0d register settings; %0d renders, %0d pixels matched",
             items_sent, settings_used, sb.renders, sb.matched);
    $display("%0d renders out of range, %0d walked the full depth without a hit",
             sb.range_errs, sb.deep_hits);
    if (sb.fails == 0 && sb.pixels_due.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

[files.f]
rtl/dcsr_pkg.sv
rtl/dcsr_ram.sv
rtl/dcsr_ctrl.sv
rtl/dcsr_datapath.sv
rtl/depth_cued_slice_renderer.sv
bench/tb_top.sv
